// File: hw/rtl/wtpd_pkg.sv
// Package for the weighted tree path distance unit.
// Holds field widths, request and status codes, and the default vertex count.
// No dependencies.
package wtpd_pkg;

    localparam int NODE_W       = 10;
    localparam int WEIGHT_W     = 16;
    localparam int DIST_W       = 26;
    localparam int CFG_W        = 11;
    localparam int STATUS_W     = 2;
    localparam int DEF_MAX_VERT = 1024;

    // Request type codes.
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_QUERY  = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_UNREACH  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_REJECTED = 2'd2;

    // Reset value of the vertex count register.
    localparam logic [CFG_W-1:0] CFG_NV_RESET = 11'd1024;

endpackage

// File: hw/rtl/wtpd_req_if.sv
// Request channel interface of the path distance unit.
// Depends on wtpd_pkg for field widths.
interface wtpd_req_if
    import wtpd_pkg::*;
    ;
    logic                valid;
    logic                ready;
    logic                req_type;
    logic [NODE_W-1:0]   node_a;
    logic [NODE_W-1:0]   node_b;
    logic [WEIGHT_W-1:0] edge_weight;

    modport source (output valid, output req_type, output node_a, output node_b,
                    output edge_weight, input ready);
    modport sink (input valid, input req_type, input node_a, input node_b,
                  input edge_weight, output ready);
endinterface

// File: hw/rtl/wtpd_rsp_if.sv
// Response channel interface of the path distance unit.
// Depends on wtpd_pkg for field widths.
interface wtpd_rsp_if
    import wtpd_pkg::*;
    ;
    logic                valid;
    logic                ready;
    logic [DIST_W-1:0]   distance;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output distance, output status, input ready);
    modport sink (input valid, input distance, input status, output ready);
endinterface

// File: hw/rtl/weighted_tree_path_distance_unit.sv
// Top level of the weighted tree path distance unit: adjacency store,
// depth-first walk sequencer and path summation.
// Depends on wtpd_pkg, wtpd_req_if, wtpd_rsp_if and wtpd_ram.
//
//  Port         Dir  Width        Purpose
//  req          in   1+10+10+16   insert edge or distance query, one per beat
//  rsp          out  26+2         distance and status, one beat per request
//  cfg_wr_en    in   1            writes num_vertices
//  cfg_wr_data  in   11           new num_vertices value
//
// After reset the adjacency heads are cleared in a sweep over all
// MAX_VERTICES entries before the first request is taken. An insert
// links the edge into the lists of node_a and node_b. A query clears the
// visited marks, walks the tree depth-first from node_a and sums the parent
// edge weights back from node_b. One request is in work at a time; a
// finished result sits in the output register while the next request enters.
module weighted_tree_path_distance_unit
    import wtpd_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERT
) (
    input  logic             clk,
    input  logic             rst_n,
    wtpd_req_if.sink         req,
    wtpd_rsp_if.source       rsp,
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data
);

    localparam int MAX_EDGES = 2 * (MAX_VERTICES - 1);
    localparam int VW        = $clog2(MAX_VERTICES);
    localparam int EW        = $clog2(2 * MAX_VERTICES - 1);
    localparam int SPW       = $clog2(MAX_VERTICES + 1);
    localparam logic [EW-1:0] EDGE_NONE = '1;

    typedef struct packed {
        logic [VW-1:0]       from;
        logic [VW-1:0]       vertex;
        logic [WEIGHT_W-1:0] weight;
    } stk_entry_t;

    typedef struct packed {
        logic [VW-1:0]       target;
        logic [WEIGHT_W-1:0] weight;
        logic [EW-1:0]       next;
    } edge_entry_t;

    typedef struct packed {
        logic [VW-1:0]       from;
        logic [WEIGHT_W-1:0] weight;
    } par_entry_t;

    typedef enum logic [15:0] {
        S_INIT    = 16'b0000_0000_0000_0001,
        S_IDLE    = 16'b0000_0000_0000_0010,
        S_INS_RA  = 16'b0000_0000_0000_0100,
        S_INS_WA  = 16'b0000_0000_0000_1000,
        S_INS_RB  = 16'b0000_0000_0001_0000,
        S_INS_WB  = 16'b0000_0000_0010_0000,
        S_Q_CLR   = 16'b0000_0000_0100_0000,
        S_Q_START = 16'b0000_0000_1000_0000,
        S_Q_POP   = 16'b0000_0001_0000_0000,
        S_Q_POPD  = 16'b0000_0010_0000_0000,
        S_Q_HEAD  = 16'b0000_0100_0000_0000,
        S_Q_EDGE  = 16'b0000_1000_0000_0000,
        S_Q_VIS   = 16'b0001_0000_0000_0000,
        S_BT      = 16'b0010_0000_0000_0000,
        S_BTD     = 16'b0100_0000_0000_0000,
        S_DONE    = 16'b1000_0000_0000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [CFG_W-1:0]    nv_reg;
    logic                type_reg, type_next;
    logic [VW-1:0]       a_reg, a_next;
    logic [VW-1:0]       b_reg, b_next;
    logic [WEIGHT_W-1:0] w_reg, w_next;
    logic [EW-1:0]       cnt_reg, cnt_next;
    logic [SPW-1:0]      sp_reg, sp_next;
    logic [SPW-1:0]      sp_dec;
    logic [VW-1:0]       sweep_reg, sweep_next;
    logic [VW-1:0]       cur_v_reg, cur_v_next;
    logic [VW-1:0]       cur_par_reg, cur_par_next;
    logic [SPW-1:0]      steps_reg, steps_next;
    logic [DIST_W-1:0]   acc_reg, acc_next;
    logic [DIST_W:0]     acc_sum;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    edge_entry_t         edge_hold_reg, edge_hold_next;
    logic                rsp_valid_reg;
    logic [DIST_W-1:0]   rsp_dist_reg;
    logic [STATUS_W-1:0] rsp_status_reg;
    logic                reject;
    logic                accept;

    // Memory ports.
    logic          head_we;
    logic [VW-1:0] head_waddr, head_raddr;
    logic [EW-1:0] head_wdata, head_rdata;
    logic          edge_we;
    logic [EW-1:0] edge_waddr, edge_raddr;
    edge_entry_t   edge_wdata, edge_rdata;
    logic          vis_we;
    logic [VW-1:0] vis_waddr, vis_raddr;
    logic          vis_wdata, vis_rdata;
    logic          stk_we;
    logic [VW-1:0] stk_waddr, stk_raddr;
    stk_entry_t    stk_wdata, stk_rdata;
    logic          par_we;
    logic [VW-1:0] par_waddr, par_raddr;
    par_entry_t    par_wdata, par_rdata;

    wtpd_ram #(.WIDTH(EW), .DEPTH(MAX_VERTICES)) u_head_ram (
        .clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
        .raddr(head_raddr), .rdata(head_rdata)
    );

    wtpd_ram #(.WIDTH($bits(edge_entry_t)), .DEPTH(MAX_EDGES)) u_edge_ram (
        .clk(clk), .we(edge_we), .waddr(edge_waddr), .wdata(edge_wdata),
        .raddr(edge_raddr), .rdata(edge_rdata)
    );

    wtpd_ram #(.WIDTH(1), .DEPTH(MAX_VERTICES)) u_vis_ram (
        .clk(clk), .we(vis_we), .waddr(vis_waddr), .wdata(vis_wdata),
        .raddr(vis_raddr), .rdata(vis_rdata)
    );

    wtpd_ram #(.WIDTH($bits(stk_entry_t)), .DEPTH(MAX_VERTICES)) u_stk_ram (
        .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
        .raddr(stk_raddr), .rdata(stk_rdata)
    );

    wtpd_ram #(.WIDTH($bits(par_entry_t)), .DEPTH(MAX_VERTICES)) u_par_ram (
        .clk(clk), .we(par_we), .waddr(par_waddr), .wdata(par_wdata),
        .raddr(par_raddr), .rdata(par_rdata)
    );

    // Handshake and range check of the incoming beat.
    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign reject    = (32'(req.node_a) >= 32'(nv_reg))
                    || (32'(req.node_b) >= 32'(nv_reg))
                    || (32'(req.node_a) >= 32'(MAX_VERTICES))
                    || (32'(req.node_b) >= 32'(MAX_VERTICES));

    assign sp_dec  = sp_reg - SPW'(1);
    assign acc_sum = {1'b0, acc_reg} + (DIST_W + 1)'(par_rdata.weight);

    assign rsp.valid    = rsp_valid_reg;
    assign rsp.distance = rsp_dist_reg;
    assign rsp.status   = rsp_status_reg;

    // Sequencer.
    always_comb
    begin
        state_next      = state_reg;
        type_next       = type_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        w_next          = w_reg;
        cnt_next        = cnt_reg;
        sp_next         = sp_reg;
        sweep_next      = sweep_reg;
        cur_v_next      = cur_v_reg;
        cur_par_next    = cur_par_reg;
        steps_next      = steps_reg;
        acc_next        = acc_reg;
        res_status_next = res_status_reg;
        edge_hold_next  = edge_hold_reg;

        head_we    = 1'b0;
        head_waddr = '0;
        head_wdata = '0;
        head_raddr = '0;
        edge_we    = 1'b0;
        edge_waddr = '0;
        edge_wdata = '0;
        edge_raddr = '0;
        vis_we     = 1'b0;
        vis_waddr  = '0;
        vis_wdata  = 1'b0;
        vis_raddr  = '0;
        stk_we     = 1'b0;
        stk_waddr  = '0;
        stk_wdata  = '0;
        stk_raddr  = '0;
        par_we     = 1'b0;
        par_waddr  = '0;
        par_wdata  = '0;
        par_raddr  = '0;

        unique case (state_reg)
            S_INIT:
            begin
                head_we    = 1'b1;
                head_waddr = sweep_reg;
                head_wdata = EDGE_NONE;
                sweep_next = sweep_reg + VW'(1);
                if (sweep_reg == VW'(MAX_VERTICES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    type_next  = req.req_type;
                    a_next     = VW'(req.node_a);
                    b_next     = VW'(req.node_b);
                    w_next     = req.edge_weight;
                    acc_next   = '0;
                    sweep_next = '0;
                    if (reject)
                    begin
                        res_status_next = STATUS_REJECTED;
                        state_next      = S_DONE;
                    end
                    else if (req.req_type == REQ_INSERT)
                    begin
                        if (({1'b0, cnt_reg} + (EW + 1)'(2)) > (EW + 1)'(MAX_EDGES))
                        begin
                            res_status_next = STATUS_REJECTED;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            state_next = S_INS_RA;
                        end
                    end
                    else
                    begin
                        state_next = S_Q_CLR;
                    end
                end
            end
            S_INS_RA:
            begin
                head_raddr = a_reg;
                state_next = S_INS_WA;
            end
            S_INS_WA:
            begin
                edge_we    = 1'b1;
                edge_waddr = cnt_reg;
                edge_wdata = '{target: b_reg, weight: w_reg, next: head_rdata};
                head_we    = 1'b1;
                head_waddr = a_reg;
                head_wdata = cnt_reg;
                state_next = S_INS_RB;
            end
            S_INS_RB:
            begin
                head_raddr = b_reg;
                state_next = S_INS_WB;
            end
            S_INS_WB:
            begin
                edge_we         = 1'b1;
                edge_waddr      = cnt_reg + EW'(1);
                edge_wdata      = '{target: a_reg, weight: w_reg, next: head_rdata};
                head_we         = 1'b1;
                head_waddr      = b_reg;
                head_wdata      = cnt_reg + EW'(1);
                cnt_next        = cnt_reg + EW'(2);
                res_status_next = STATUS_OK;
                state_next      = S_DONE;
            end
            S_Q_CLR:
            begin
                vis_we     = 1'b1;
                vis_waddr  = sweep_reg;
                vis_wdata  = 1'b0;
                sweep_next = sweep_reg + VW'(1);
                if (sweep_reg == VW'(MAX_VERTICES - 1))
                begin
                    state_next = S_Q_START;
                end
            end
            S_Q_START:
            begin
                stk_we     = 1'b1;
                stk_waddr  = '0;
                stk_wdata  = '{from: a_reg, vertex: a_reg, weight: '0};
                vis_we     = 1'b1;
                vis_waddr  = a_reg;
                vis_wdata  = 1'b1;
                sp_next    = SPW'(1);
                state_next = S_Q_POP;
            end
            S_Q_POP:
            begin
                if (sp_reg == '0)
                begin
                    res_status_next = STATUS_UNREACH;
                    state_next      = S_DONE;
                end
                else
                begin
                    stk_raddr  = sp_dec[VW-1:0];
                    sp_next    = sp_dec;
                    state_next = S_Q_POPD;
                end
            end
            S_Q_POPD:
            begin
                par_we     = 1'b1;
                par_waddr  = stk_rdata.vertex;
                par_wdata  = '{from: stk_rdata.from, weight: stk_rdata.weight};
                cur_v_next = stk_rdata.vertex;
                if (stk_rdata.vertex == b_reg)
                begin
                    cur_par_next = stk_rdata.from;
                    acc_next     = DIST_W'(stk_rdata.weight);
                    steps_next   = '0;
                    state_next   = S_BT;
                end
                else
                begin
                    head_raddr = stk_rdata.vertex;
                    state_next = S_Q_HEAD;
                end
            end
            S_Q_HEAD:
            begin
                if (head_rdata == EDGE_NONE)
                begin
                    state_next = S_Q_POP;
                end
                else
                begin
                    edge_raddr = head_rdata;
                    state_next = S_Q_EDGE;
                end
            end
            S_Q_EDGE:
            begin
                edge_hold_next = edge_rdata;
                vis_raddr      = edge_rdata.target;
                state_next     = S_Q_VIS;
            end
            S_Q_VIS:
            begin
                // Push an unvisited neighbor and mark it.
                if (!vis_rdata)
                begin
                    stk_we    = 1'b1;
                    stk_waddr = sp_reg[VW-1:0];
                    stk_wdata = '{from: cur_v_reg, vertex: edge_hold_reg.target,
                                  weight: edge_hold_reg.weight};
                    vis_we    = 1'b1;
                    vis_waddr = edge_hold_reg.target;
                    vis_wdata = 1'b1;
                    sp_next   = sp_reg + SPW'(1);
                end
                if (edge_hold_reg.next == EDGE_NONE)
                begin
                    state_next = S_Q_POP;
                end
                else
                begin
                    edge_raddr = edge_hold_reg.next;
                    state_next = S_Q_EDGE;
                end
            end
            S_BT:
            begin
                if ((cur_par_reg == a_reg) || (steps_reg == SPW'(MAX_VERTICES)))
                begin
                    res_status_next = STATUS_OK;
                    state_next      = S_DONE;
                end
                else
                begin
                    par_raddr  = cur_par_reg;
                    state_next = S_BTD;
                end
            end
            S_BTD:
            begin
                // Saturating accumulate of the parent edge weight.
                acc_next     = acc_sum[DIST_W] ? '1 : acc_sum[DIST_W-1:0];
                cur_par_next = par_rdata.from;
                steps_next   = steps_reg + SPW'(1);
                state_next   = S_BT;
            end
            S_DONE:
            begin
                if (!rsp_valid_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            nv_reg        <= CFG_NV_RESET;
            cnt_reg       <= '0;
            sp_reg        <= '0;
            sweep_reg     <= '0;
            steps_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            sp_reg    <= sp_next;
            sweep_reg <= sweep_next;
            steps_reg <= steps_next;
            if (cfg_wr_en)
            begin
                nv_reg <= cfg_wr_data;
            end
            if (state_reg == S_DONE && !rsp_valid_reg)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        type_reg       <= type_next;
        a_reg          <= a_next;
        b_reg          <= b_next;
        w_reg          <= w_next;
        cur_v_reg      <= cur_v_next;
        cur_par_reg    <= cur_par_next;
        acc_reg        <= acc_next;
        res_status_reg <= res_status_next;
        edge_hold_reg  <= edge_hold_next;
        if (state_reg == S_DONE && !rsp_valid_reg)
        begin
            rsp_status_reg <= res_status_reg;
            rsp_dist_reg   <= (type_reg == REQ_QUERY && res_status_reg == STATUS_OK)
                              ? acc_reg : '0;
        end
    end

    // The walk stack never holds more than one entry per vertex.
    assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SPW'(MAX_VERTICES))
        else $error("walk stack pointer beyond vertex count");

    // Edge slots are only written while two free slots were known to remain.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INS_WA) |-> (({1'b0, cnt_reg} + (EW + 1)'(2))
                                     <= (EW + 1)'(MAX_EDGES)))
        else $error("insert running with a full edge store");

    // A result beat appears only out of the completion state.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside completion");

    // The edge count grows only by two and only at the second link write.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != $past(cnt_reg)) |-> $past(state_reg == S_INS_WB))
        else $error("edge count changed outside an insert");

endmodule

// File: hw/rtl/wtpd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module wtpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
